// File: design/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared widths and defaults for the prime-pair partition counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int MAX_VALUE_DEF = 4096;
  localparam int N_W           = 13;
  localparam int COUNT_W       = 12;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 16;
  localparam int FLAG_W        = 1;

endpackage

// File: design/gpc_ram.sv
// ----------------------------------------------------------------------------
// gpc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gpc_ram #(
  parameter int WIDTH = gpc_pkg::FLAG_W,
  parameter int DEPTH = gpc_pkg::MAX_VALUE_DEF + 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/goldbach_partition_counter.sv
// ----------------------------------------------------------------------------
// goldbach_partition_counter
// Counts the ways to write n as p + q with p <= q, both prime.
//
// Usage:
//   Slave stream s_* carries one query n per transaction in s_tdata[12:0].
//   Master stream m_* returns one pair count per query in m_tdata[11:0].
//   Each query rebuilds a primality bitmap for 0..n with the sieve of
//   Eratosthenes in two mirrored 1-bit RAMs of MAX_VALUE+1 entries, then
//   scans p = 2..n/2, reading p and n-p in the same cycle, one per RAM.
//   For 2 <= n <= MAX_VALUE a query fills entries 0..n of the bitmap,
//   then for each sieve base up to sqrt(n) reads and checks its flag and
//   strikes its multiples from 2*base up to n, then counts the pairs.
//   Every write goes through the shared write port, one entry a cycle;
//   each RAM has its own read port.
//   n below 2 or above MAX_VALUE answers 0 without building the bitmap.
//   One query is processed at a time; s_tready is high when no query is
//   in progress, even while a finished result waits in the output register.
//   A stalled receiver holds the result; a finished query then waits.
//   Synchronous reset clears the control state; the RAM contents are not
//   cleared, as every query writes its entries before reading them.
// ----------------------------------------------------------------------------
module goldbach_partition_counter #(
  parameter int MAX_VALUE = gpc_pkg::MAX_VALUE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gpc_pkg::IN_TDATA_W-1:0]   s_tdata,   // [12:0] n
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gpc_pkg::OUT_TDATA_W-1:0]  m_tdata    // [11:0] pair_count
);

  localparam int DEPTH = MAX_VALUE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_STRIKE = 3'd4;
  localparam logic [2:0] S_CNT    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                    state;
  logic [AW-1:0]                 n_reg;
  logic [CW-1:0]                 i;
  logic [CW-1:0]                 j;
  logic [CW-1:0]                 sq;
  logic [CW-1:0]                 p;
  logic [gpc_pkg::COUNT_W-1:0]   count;
  logic                          rd_pend;
  logic [gpc_pkg::COUNT_W-1:0]   m_count;

  logic [gpc_pkg::N_W-1:0]       in_n;
  logic                          in_ok;
  logic                          s_fire;
  logic [CW-1:0]                 n_ext;
  logic [CW-1:0]                 half;
  logic [CW-1:0]                 i_next;
  logic [CW-1:0]                 sq_next;
  logic [CW-1:0]                 j_next;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [gpc_pkg::FLAG_W-1:0]    ram_wdata;
  logic [AW-1:0]                 raddr_a;
  logic [AW-1:0]                 raddr_b;
  logic [gpc_pkg::FLAG_W-1:0]    rdata_a;
  logic [gpc_pkg::FLAG_W-1:0]    rdata_b;

  assign in_n     = s_tdata[gpc_pkg::N_W-1:0];
  assign in_ok    = (32'(in_n) >= 32'd2) && (32'(in_n) <= 32'(MAX_VALUE));
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  assign n_ext   = CW'(n_reg);
  assign half    = CW'(n_reg >> 1);
  assign i_next  = i + CW'(1);
  assign sq_next = CW'(sq + CW'({i, 1'b0}) + CW'(1));
  assign j_next  = j + i;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i[AW-1:0];
    ram_wdata = '0;
    raddr_a   = i[AW-1:0];
    raddr_b   = i[AW-1:0];
    case (state)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = i[AW-1:0];
        ram_wdata = gpc_pkg::FLAG_W'(i >= CW'(2));
      end
      S_STRIKE: begin
        ram_we    = 1'b1;
        ram_waddr = j[AW-1:0];
        ram_wdata = '0;
      end
      S_CNT: begin
        raddr_a = p[AW-1:0];
        raddr_b = n_reg - p[AW-1:0];
      end
      default: begin
        raddr_a = i[AW-1:0];
      end
    endcase
  end

  gpc_ram #(
    .WIDTH (gpc_pkg::FLAG_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  gpc_ram #(
    .WIDTH (gpc_pkg::FLAG_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= (state == S_CNT) && (p <= half);
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_count  <= count;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (rd_pend && rdata_a[0] && rdata_b[0] && (count != '1)) begin
        count <= count + gpc_pkg::COUNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            n_reg <= AW'(in_n);
            i     <= '0;
            count <= '0;
            state <= in_ok ? S_FILL : S_DONE;
          end
        end
        S_FILL: begin
          if (i == n_ext) begin
            i     <= CW'(2);
            sq    <= CW'(4);
            state <= S_RD;
          end else begin
            i <= i_next;
          end
        end
        S_RD: begin
          if (sq > n_ext) begin
            p     <= CW'(2);
            state <= S_CNT;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rdata_a[0]) begin
            j     <= CW'({i, 1'b0});
            state <= S_STRIKE;
          end else begin
            i     <= i_next;
            sq    <= sq_next;
            state <= S_RD;
          end
        end
        S_STRIKE: begin
          j <= j_next;
          if (j_next > n_ext) begin
            i     <= i_next;
            sq    <= sq_next;
            state <= S_RD;
          end
        end
        S_CNT: begin
          if (p <= half) begin
            p <= p + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(gpc_pkg::OUT_TDATA_W - gpc_pkg::COUNT_W){1'b0}}, m_count};

  a_pend_from_count: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == S_CNT)
    else $error("count read retired without a count-phase issue");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ram_waddr <= n_reg)
    else $error("bitmap write beyond the query value");

  a_small_n_zero: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (in_n < gpc_pkg::N_W'(2))) |=> (state == S_DONE && count == '0))
    else $error("small query did not go straight to a zero result");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result presented outside the done step");

endmodule
